// ===== hw/rtl/b64d_pkg.sv =====
// b64d_pkg: shared types, codes and the alphabet lookup for the base64 stream decoder
// no dependencies; imported by every block module
`default_nettype none

package b64d_pkg;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;

    // special character codes
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one unit of work for the back end: one to three results
    typedef struct packed {
        logic [23:0] group_bits;  // bytes taken from the top down
        logic [1:0]  res_count;   // number of results, 1..3
        logic        has_bytes;   // results carry decoded bytes
        logic [1:0]  status;
        logic        last;        // final result closes the string
    } b64d_job_t;

    // alphabet lookup: {valid, value}
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    // bytes produced by a group with the given pad total
    function automatic logic [1:0] bytes_for_pads(input logic [2:0] pads);
        logic [1:0] n;
        if (pads == 3'd0)
        begin
            n = 2'd3;
        end
        else if (pads == 3'd1)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_stream_if.sv =====
// b64d_stream_if: valid/ready channels for characters in and decoded results out
// no dependencies
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_string;
    logic [1:0] status;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_of_string, output status, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input last_of_string, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// b64d_front: accepts characters, keeps the group state and builds result jobs
// depends on b64d_pkg
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_text,
    input  wire logic       queue_full,
    output logic            job_push,
    output b64d_job_t       job
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  gc_reg, gc_next;
    logic [2:0]  pc_reg, pc_next;
    logic        seen_reg, seen_next;
    logic        disc_reg, disc_next;

    logic        accept;
    logic        is_ws;
    logic        is_pad;
    logic [6:0]  sym;
    logic        has_job;
    logic [23:0] acc_k;
    logic [2:0]  pc_k;
    logic [2:0]  missing;
    logic [23:0] acc_fill;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign job_push = accept && has_job;

    // character classification
    assign is_ws  = (char_code == CHAR_SPACE) ||
                    (char_code >= CHAR_TAB && char_code <= CHAR_CR);
    assign is_pad = (char_code == CHAR_PAD);
    assign sym    = sym_decode(char_code);

    // next state and job
    always_comb
    begin
        acc_next  = acc_reg;
        gc_next   = gc_reg;
        pc_next   = pc_reg;
        seen_next = seen_reg;
        disc_next = disc_reg;
        has_job   = 1'b0;
        job       = '0;
        acc_k     = {acc_reg[17:0], (is_pad ? 6'd0 : sym[5:0])};
        pc_k      = pc_reg + {2'b00, is_pad};
        missing   = 3'd4 - {1'b0, gc_reg};
        acc_fill  = '0;

        if (disc_reg)
        begin
            if (end_of_text)
            begin
                has_job       = 1'b1;
                job.res_count = 2'd1;
                job.status    = STAT_INVALID;
                job.last      = 1'b1;
                disc_next     = 1'b0;
                acc_next      = '0;
                gc_next       = '0;
                pc_next       = '0;
                seen_next     = 1'b0;
            end
        end
        else if (!is_ws && !is_pad && !sym[6])
        begin
            // invalid character
            has_job       = 1'b1;
            job.res_count = 2'd1;
            job.status    = STAT_INVALID;
            job.last      = end_of_text;
            if (end_of_text)
            begin
                acc_next  = '0;
                gc_next   = '0;
                pc_next   = '0;
                seen_next = 1'b0;
            end
            else
            begin
                disc_next = 1'b1;
            end
        end
        else
        begin
            if (!is_ws)
            begin
                seen_next = 1'b1;
                if (gc_reg == 2'd3)
                begin
                    has_job        = 1'b1;
                    job.group_bits = acc_k;
                    job.res_count  = bytes_for_pads(pc_k);
                    job.has_bytes  = 1'b1;
                    job.status     = STAT_OK;
                    acc_next       = '0;
                    gc_next        = '0;
                    pc_next        = '0;
                end
                else
                begin
                    acc_next = acc_k;
                    gc_next  = gc_reg + 2'd1;
                    pc_next  = pc_k;
                end
            end

            if (end_of_text)
            begin
                // partial group is padded out to full width
                missing = 3'd4 - {1'b0, gc_next};
                case (gc_next)
                    2'd1:    acc_fill = {acc_next[5:0], 18'd0};
                    2'd2:    acc_fill = {acc_next[11:0], 12'd0};
                    2'd3:    acc_fill = {acc_next[17:0], 6'd0};
                    default: acc_fill = '0;
                endcase
                if (!seen_next)
                begin
                    has_job       = 1'b1;
                    job           = '0;
                    job.res_count = 2'd1;
                    job.status    = STAT_EMPTY;
                end
                else if (gc_next != 2'd0)
                begin
                    has_job        = 1'b1;
                    job.group_bits = acc_fill;
                    job.res_count  = bytes_for_pads(pc_next + missing);
                    job.has_bytes  = 1'b1;
                    job.status     = STAT_OK;
                end
                else if (!has_job)
                begin
                    has_job       = 1'b1;
                    job.res_count = 2'd1;
                    job.status    = STAT_OK;
                end
                job.last  = 1'b1;
                acc_next  = '0;
                gc_next   = '0;
                pc_next   = '0;
                seen_next = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            gc_reg   <= '0;
            pc_reg   <= '0;
            seen_reg <= 1'b0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            gc_reg   <= gc_next;
            pc_reg   <= pc_next;
            seen_reg <= seen_next;
            disc_reg <= disc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_queue.sv =====
// b64d_queue: small job queue between the front and back ends
// depends on b64d_pkg
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire b64d_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output b64d_job_t      head_job,
    output logic           empty
);

    b64d_job_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots_reg[rd_ptr_reg];

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// b64d_back: expands each job into result transactions through an output register
// depends on b64d_pkg
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire b64d_job_t head_job,
    input  wire logic      queue_empty,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [7:0]     data_byte,
    output logic           byte_valid,
    output logic           last_of_string,
    output logic [1:0]     status
);

    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       bv_reg;
    logic       last_reg, last_next;
    logic [1:0] status_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       final_res;

    assign out_valid      = valid_reg;
    assign data_byte      = byte_reg;
    assign byte_valid     = bv_reg;
    assign last_of_string = last_reg;
    assign status         = status_reg;

    // load the next result when the output register is free
    assign load      = !queue_empty && (!valid_reg || out_ready);
    assign final_res = (idx_reg == head_job.res_count - 2'd1);
    assign pop       = load && final_res;

    // byte selection by result index
    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_next = head_job.group_bits[23:16];
            2'd1:    byte_next = head_job.group_bits[15:8];
            2'd2:    byte_next = head_job.group_bits[7:0];
            default: byte_next = '0;
        endcase
        if (!head_job.has_bytes)
        begin
            byte_next = '0;
        end
        last_next = head_job.last && final_res;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            bv_reg     <= head_job.has_bytes;
            last_reg   <= last_next;
            status_reg <= head_job.status;
        end
    end

    // output valid and result index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_res ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder_unit.sv =====
// base64_stream_decoder_unit: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_stream_if, b64d_front, b64d_queue, b64d_back
//
//  channel   dir  payload                                          transaction
//  chars     in   char_code[7:0], end_of_text                      one character
//  decoded   out  data_byte[7:0], byte_valid, last_of_string,      one result
//                 status[1:0]
//
// a character is taken every cycle while the four-entry job queue has room
// each character yields zero to three results, sent one per ready cycle from the
// output register, so sustained rate is set by the result count of the back end
// first result passes through the job queue and the output register
// reset clears the group state, the queue and the output register
`default_nettype none

module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64d_char_if.sink   chars,
    b64d_byte_if.source decoded
);

    b64d_job_t push_job;
    b64d_job_t head_job;
    logic      job_push;
    logic      queue_full;
    logic      queue_empty;
    logic      job_pop;

    // character classification and group state
    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chars.valid),
        .in_ready    (chars.ready),
        .char_code   (chars.char_code),
        .end_of_text (chars.end_of_text),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    // decoupling queue
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    // result expansion and output register
    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .queue_empty    (queue_empty),
        .pop            (job_pop),
        .out_valid      (decoded.valid),
        .out_ready      (decoded.ready),
        .data_byte      (decoded.data_byte),
        .byte_valid     (decoded.byte_valid),
        .last_of_string (decoded.last_of_string),
        .status         (decoded.status)
    );

endmodule

`default_nettype wire

// ===== test/b64d_result_checker.sv =====
`timescale 1ns / 100ps
// b64d_result_checker: watches the character and result channels of the decoder,
// predicts the decoded results and compares them; depends on b64d_pkg

module b64d_result_checker
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       last_of_string,
    input  logic [1:0] status,
    output int         fail_count,
    output int         pending_count
);

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_of_string;
        logic [1:0] status;
    } decoded_result_t;

    // results still owed by the block, oldest first
    decoded_result_t owed_results[$];

    // decoder state as the predictor sees it
    logic [23:0] group_bits;
    int          kept_in_group;
    int          pads_in_group;
    bit          symbol_seen;
    bit          skipping;

    // results produced by the current character
    decoded_result_t char_results[3];
    int              char_result_count;

    function automatic void clear_string_state();
        group_bits    = '0;
        kept_in_group = 0;
        pads_in_group = 0;
        symbol_seen   = 0;
        skipping      = 0;
    endfunction

    // alphabet position, or -1 for a character outside it
    function automatic int alphabet_index(input logic [7:0] c);
        int idx;
        idx = -1;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            idx = int'(c) - 8'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            idx = int'(c) - 8'h61 + 26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            idx = int'(c) - 8'h30 + 52;
        end
        else if (c == 8'h2B)
        begin
            idx = 62;
        end
        else if (c == 8'h2F)
        begin
            idx = 63;
        end
        return idx;
    endfunction

    function automatic void add_result(input logic [7:0] value, input logic has_byte,
                                       input logic [1:0] code);
        char_results[char_result_count].data_byte      = value;
        char_results[char_result_count].byte_valid     = has_byte;
        char_results[char_result_count].last_of_string = 1'b0;
        char_results[char_result_count].status         = code;
        char_result_count++;
    endfunction

    // bytes of a full group, fewer as the pad total grows
    function automatic void add_group_bytes(input logic [23:0] bits, input int pads);
        add_result(bits[23:16], 1'b1, STAT_OK);
        if (pads < 2)
        begin
            add_result(bits[15:8], 1'b1, STAT_OK);
        end
        if (pads < 1)
        begin
            add_result(bits[7:0], 1'b1, STAT_OK);
        end
    endfunction

    // work out the results of one accepted character
    function automatic void decode_char(input logic [7:0] c, input logic last_char);
        int          sym;
        int          missing;
        logic [5:0]  bits6;
        logic [23:0] filled;
        bit          blank;
        char_result_count = 0;
        if (skipping)
        begin
            // after an error only the end of the string matters
            if (last_char)
            begin
                add_result(8'h00, 1'b0, STAT_INVALID);
                char_results[0].last_of_string = 1'b1;
                clear_string_state();
            end
        end
        else
        begin
            blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
            sym = 0;
            if (!blank && c != CHAR_PAD)
            begin
                sym = alphabet_index(c);
            end
            if (sym < 0)
            begin
                // invalid character
                add_result(8'h00, 1'b0, STAT_INVALID);
                char_results[0].last_of_string = last_char;
                if (last_char)
                begin
                    clear_string_state();
                end
                else
                begin
                    skipping = 1;
                end
            end
            else
            begin
                if (!blank)
                begin
                    if (c == CHAR_PAD)
                    begin
                        pads_in_group++;
                    end
                    bits6 = sym[5:0];
                    symbol_seen = 1;
                    group_bits = {group_bits[17:0], bits6};
                    if (kept_in_group == 3)
                    begin
                        add_group_bytes(group_bits, pads_in_group);
                        group_bits    = '0;
                        kept_in_group = 0;
                        pads_in_group = 0;
                    end
                    else
                    begin
                        kept_in_group++;
                    end
                end
                if (last_char)
                begin
                    if (!symbol_seen)
                    begin
                        add_result(8'h00, 1'b0, STAT_EMPTY);
                    end
                    else if (kept_in_group != 0)
                    begin
                        // partial group padded out
                        missing = 4 - kept_in_group;
                        filled  = group_bits << (6 * missing);
                        add_group_bytes(filled, pads_in_group + missing);
                    end
                    else if (char_result_count == 0)
                    begin
                        add_result(8'h00, 1'b0, STAT_OK);
                    end
                    char_results[char_result_count - 1].last_of_string = 1'b1;
                    clear_string_state();
                end
            end
        end
        for (int i = 0; i < char_result_count; i++)
        begin
            owed_results.insert(owed_results.size(), char_results[i]);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // predict on each accepted character, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        decoded_result_t want;
        if (!rst_n)
        begin
            clear_string_state();
            owed_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (char_valid === 1'b1 && char_ready === 1'b1)
            begin
                decode_char(char_code, end_of_text);
            end
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: data_byte %0d byte_valid %0d last %0d status %0d",
                           data_byte, byte_valid, last_of_string, status);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("byte_valid", want.byte_valid, byte_valid);
                    check_field("last_of_string", want.last_of_string, last_of_string);
                    check_field("status", want.status, status);
                end
            end
            pending_count = owed_results.size();
        end
    end

endmodule

// ===== test/base64_stream_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// base64_stream_decoder_unit_tb: clock, reset and character stimulus for the decoder
// depends on b64d_pkg, b64d_stream_if, base64_stream_decoder_unit, b64d_result_checker

module base64_stream_decoder_unit_tb;
    import b64d_pkg::*;

    typedef logic [7:0] char_q_t[$];

    localparam int RANDOM_ITEMS = 250;
    localparam int LONG_HOLD    = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending_count;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_seq;
    int hold_done;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    b64d_char_if chars_if ();
    b64d_byte_if decoded_if ();

    base64_stream_decoder_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .decoded (decoded_if)
    );

    b64d_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (chars_if.valid),
        .char_ready     (chars_if.ready),
        .char_code      (chars_if.char_code),
        .end_of_text    (chars_if.end_of_text),
        .out_valid      (decoded_if.valid),
        .out_ready      (decoded_if.ready),
        .data_byte      (decoded_if.data_byte),
        .byte_valid     (decoded_if.byte_valid),
        .last_of_string (decoded_if.last_of_string),
        .status         (decoded_if.status),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        decoded_if.ready = 1'b0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_done)
            begin
                hold_done = hold_seq;
                decoded_if.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                decoded_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic char_q_t text_chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q.insert(q.size(), s[i]);
        end
        return q;
    endfunction

    function automatic logic [7:0] random_blank();
        logic [7:0] blanks[6];
        blanks = '{CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, CHAR_SPACE};
        return blanks[$urandom_range(5)];
    endfunction

    // one encoded string: mostly well formed, some damaged, some noise
    function automatic char_q_t make_string();
        char_q_t     text;
        char_q_t     coded;
        logic [7:0]  raw[$];
        logic [23:0] grp;
        int          kind;
        int          nbytes;
        int          take;
        int          pos;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 5)) text.insert(text.size(), 8'($urandom_range(255)));
            return text;
        end
        if (kind < 19)
        begin
            repeat ($urandom_range(1, 3)) text.insert(text.size(), random_blank());
            return text;
        end
        nbytes = $urandom_range(1, 7);
        repeat (nbytes) raw.insert(raw.size(), 8'($urandom_range(255)));
        for (int i = 0; i < nbytes; i += 3)
        begin
            take = (nbytes - i > 3) ? 3 : nbytes - i;
            grp = {raw[i], (take > 1) ? raw[i + 1] : 8'h00, (take > 2) ? raw[i + 2] : 8'h00};
            coded.insert(coded.size(), alphabet[grp[23:18]]);
            coded.insert(coded.size(), alphabet[grp[17:12]]);
            coded.insert(coded.size(), (take > 1) ? alphabet[grp[11:6]] : CHAR_PAD);
            coded.insert(coded.size(), (take > 2) ? alphabet[grp[5:0]] : CHAR_PAD);
        end
        // padding left off now and then
        if ($urandom_range(99) < 30)
        begin
            while (coded.size() > 1 && coded[coded.size() - 1] == CHAR_PAD)
            begin
                void'(coded.pop_back());
            end
        end
        // damaged string: a random byte or a stray pad
        if (kind < 33)
        begin
            pos = $urandom_range(coded.size() - 1);
            coded[pos] = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : CHAR_PAD;
        end
        foreach (coded[i])
        begin
            if ($urandom_range(99) < 15)
            begin
                text.insert(text.size(), random_blank());
            end
            text.insert(text.size(), coded[i]);
        end
        if ($urandom_range(99) < 20)
        begin
            text.insert(text.size(), random_blank());
        end
        return text;
    endfunction

    // one character transaction, with random idle cycles in front
    task automatic send_char(input logic [7:0] c, input logic last_char);
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid = 1'b0;
            @(negedge clk);
        end
        chars_if.valid       = 1'b1;
        chars_if.char_code   = c;
        chars_if.end_of_text = last_char;
        @(posedge clk);
        while (chars_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input char_q_t q);
        foreach (q[i])
        begin
            send_char(q[i], i == q.size() - 1);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        chars_if.valid       = 1'b0;
        chars_if.char_code   = 8'h00;
        chars_if.end_of_text = 1'b0;
        items_sent    = 0;
        hold_seq      = 0;
        send_idle_pct = 26;
        recv_idle_pct = 55;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full group, two pads, blank-only string
        send_text(text_chars("TWFu"));
        send_text(text_chars("TQ=="));
        send_text(text_chars(" "));
        // all-ones group, then a blank end on an empty group
        send_text('{8'h2F, 8'h2F, 8'h2F, 8'h2F, 8'h0A});
        // invalid character, rest discarded up to the end
        send_text('{8'h2B, 8'hFF, 8'h41, 8'h7A});
        // high code with the end flag
        send_text('{8'h80});
        // pads inside a group, then a lone partial group
        send_text(text_chars("=A=9"));
        send_text(text_chars("0"));

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS / 3 && send_idle_pct == 26)
            begin
                // swap idle rates and let the results back up
                send_idle_pct = 55;
                recv_idle_pct = 26;
                hold_seq++;
            end
            else if (items_sent >= 2 * RANDOM_ITEMS / 3 && send_idle_pct == 55)
            begin
                // drain completely, then stream with no idling
                chars_if.valid = 1'b0;
                wait (pending_count == 0);
                @(negedge clk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_text(make_string());
        end
        chars_if.valid = 1'b0;

        wait (pending_count == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_stream_if.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder_unit.sv
test/b64d_result_checker.sv
test/base64_stream_decoder_unit_tb.sv
